FILE: rtl/gnta_pkg.sv
// shared constants, codes and table entry types of the track associator
`default_nettype none

package gnta_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int MAX_DETS   = 16;
  localparam int CLASS_BITS = 3;
  localparam int COORD_BITS = 12;

  localparam int TIDX_W   = $clog2(MAX_TRACKS);
  localparam int TCNT_W   = $clog2(MAX_TRACKS + 1);
  localparam int DIDX_W   = $clog2(MAX_DETS);
  localparam int DCNT_W   = $clog2(MAX_DETS + 1);
  localparam int TIME_W   = 32;
  localparam int GATE_W   = 26;
  localparam int TOUT_W   = 16;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int DIST_W   = SQ_W + 1;
  localparam int CMP_W    = (DIST_W > GATE_W) ? DIST_W : GATE_W;
  localparam int PROD_W   = COORD_BITS + 1 + TIME_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int DEN_W    = TIME_W;
  localparam int DIVC_W   = $clog2(NUM_W + 1);
  localparam int EST_W    = 16;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 2;
  localparam int CFG_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(4000000);
  localparam logic [TOUT_W-1:0] TOUT_RESET = TOUT_W'(400);
  localparam logic [TCNT_W-1:0] TRACKS_FULL = TCNT_W'(MAX_TRACKS);
  localparam logic [DCNT_W-1:0] DETS_FULL = DCNT_W'(MAX_DETS);
  localparam logic [1:0] CNT_SAT = 2'd2;
  localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(32767);
  localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(32768);
  localparam logic signed [EST_W-1:0] EST_MAX = 16'sh7fff;
  localparam logic signed [EST_W-1:0] EST_MIN = -16'sh8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_DET,
    CMD_EOF,
    CMD_PRUNE,
    CMD_EXTRAP
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NO_TRACK,
    ST_FEW_SIGHTINGS,
    ST_ZERO_DT,
    ST_DROPPED
  } status_e;

  typedef enum logic {
    REG_GATE,
    REG_TIMEOUT
  } reg_e;

  typedef struct packed {
    logic [CLASS_BITS-1:0] kind;
    logic [COORD_BITS-1:0] nx;
    logic [COORD_BITS-1:0] ny;
    logic [COORD_BITS-1:0] nw;
    logic [COORD_BITS-1:0] nh;
    logic [TIME_W-1:0]     ntime;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [TIME_W-1:0]     ptime;
    logic [1:0]            cnt;
  } track_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [CLASS_BITS-1:0] kind;
  } det_t;

  localparam int TRACK_W = $bits(track_t);
  localparam int DET_W   = $bits(det_t);

endpackage

`default_nettype wire

FILE: rtl/gnta_ram.sv
// generic single write port ram with registered read
`default_nettype none

module gnta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/gnta_div.sv
// bit-serial restoring divider for unsigned magnitudes
`default_nettype none

module gnta_div
  import gnta_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quotient_o
);

  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [DIVC_W-1:0] cnt_q;
  logic              done_q;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = !diff[DEN_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= dividend_i;
        rem_q <= '0;
        den_q <= divisor_i;
        cnt_q <= DIVC_W'(NUM_W);
      end else if (cnt_q != '0) begin
        rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - DIVC_W'(1);
        if (cnt_q == DIVC_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: rtl/greedy_nearest_track_associator_unit.sv
// top level of the greedy nearest neighbor track associator
`default_nettype none

// Every beat on the input gives exactly one beat on the output. The track table
// and the detection buffer live in two synchronous RAMs walked by one sequencer,
// so one item is worked at a time; a finished result waits in the output
// register while the next item is taken. The distance scan at end of frame
// reads one buffered detection from the RAM per cycle. An extrapolation that
// reaches the division runs the bit-serial divider once per coordinate.
// There is no clearing pass after reset.
module greedy_nearest_track_associator_unit
  import gnta_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic      [APB_DW-1:0]     prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [CMD_W-1:0]      cmd_i,
  input  wire logic [COORD_BITS-1:0] box_x_i,
  input  wire logic [COORD_BITS-1:0] box_y_i,
  input  wire logic [COORD_BITS-1:0] box_width_i,
  input  wire logic [COORD_BITS-1:0] box_height_i,
  input  wire logic [CLASS_BITS-1:0] det_class_i,
  input  wire logic [TIME_W-1:0]     time_now_i,
  input  wire logic [TIDX_W-1:0]     track_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [STATUS_W-1:0]   status_o,
  output logic signed [EST_W-1:0]    est_x_o,
  output logic signed [EST_W-1:0]    est_y_o,
  output logic      [COORD_BITS-1:0] est_width_o,
  output logic      [COORD_BITS-1:0] est_height_o,
  output logic      [CLASS_BITS-1:0] est_class_o,
  output logic      [TCNT_W-1:0]     live_tracks_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_E_TRD,
    S_E_TLD,
    S_E_SCAN,
    S_E_TWR,
    S_A_RD,
    S_A_CHK,
    S_P_RD,
    S_P_CHK,
    S_X_RD,
    S_X_LD,
    S_X_CHK,
    S_X_MUL,
    S_X_SUM,
    S_X_GO,
    S_X_DIV,
    S_X_SAT,
    S_EMIT
  } state_e;

  // config registers
  logic [GATE_W-1:0] gate_q;
  logic [TOUT_W-1:0] tout_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= GATE_RESET;
      tout_q <= TOUT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_GATE:    gate_q <= pwdata[GATE_W-1:0];
        REG_TIMEOUT: tout_q <= pwdata[TOUT_W-1:0];
        default:     gate_q <= gate_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_GATE:    prdata = APB_DW'(gate_q);
      REG_TIMEOUT: prdata = APB_DW'(tout_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer registers
  state_e                       state_q;
  cmd_e                         cmd_q;
  status_e                      res_q;
  logic [TIME_W-1:0]            now_q;
  logic [TIDX_W-1:0]            idx_q;
  logic [TCNT_W-1:0]            tt_q;
  logic [DCNT_W-1:0]            pend_q;
  logic [TCNT_W-1:0]            ti_q;
  logic [TCNT_W-1:0]            wi_q;
  logic [DCNT_W-1:0]            iss_q;
  logic [DCNT_W-1:0]            aj_q;
  logic [MAX_DETS-1:0]          taken_q;
  logic                         drop_q;
  logic                         rd_v_q;
  logic [DIDX_W-1:0]            rd_j_q;
  logic                         s2_v_q;
  logic                         s2_el_q;
  logic [DIDX_W-1:0]            s2_j_q;
  logic [SQ_W-1:0]              s2_sqx_q;
  logic [SQ_W-1:0]              s2_sqy_q;
  det_t                         s2_det_q;
  logic [CMP_W-1:0]             best_q;
  logic                         pick_v_q;
  logic [DIDX_W-1:0]            pick_j_q;
  det_t                         pick_det_q;
  track_t                       trk_q;
  logic                         coord_q;
  logic signed [TIME_W-1:0]     dt_q;
  logic signed [TIME_W-1:0]     e_q;
  logic signed [PROD_W-1:0]     p1_q;
  logic signed [PROD_W-1:0]     p2_q;
  logic signed [NUM_W-1:0]      num_q;
  logic                         neg_q;
  logic signed [EST_W-1:0]      est_x_q;
  logic signed [EST_W-1:0]      est_y_q;
  logic                         out_valid_q;
  logic [STATUS_W-1:0]          out_status_q;
  logic signed [EST_W-1:0]      out_x_q;
  logic signed [EST_W-1:0]      out_y_q;
  logic [COORD_BITS-1:0]        out_w_q;
  logic [COORD_BITS-1:0]        out_h_q;
  logic [CLASS_BITS-1:0]        out_k_q;
  logic [TCNT_W-1:0]            out_live_q;

  // memories
  track_t              trk_rdata;
  track_t              trk_wdata;
  logic                trk_we;
  logic [TIDX_W-1:0]   trk_waddr;
  logic [TIDX_W-1:0]   trk_raddr;
  det_t                det_rdata;
  det_t                det_wdata;
  logic                det_we;
  logic [DIDX_W-1:0]   det_raddr;

  gnta_ram #(
    .WIDTH(TRACK_W),
    .DEPTH(MAX_TRACKS)
  ) u_track_ram (
    .clk_i   (clk_i),
    .we_i    (trk_we),
    .waddr_i (trk_waddr),
    .wdata_i (trk_wdata),
    .raddr_i (trk_raddr),
    .rdata_o (trk_rdata)
  );

  gnta_ram #(
    .WIDTH(DET_W),
    .DEPTH(MAX_DETS)
  ) u_det_ram (
    .clk_i   (clk_i),
    .we_i    (det_we),
    .waddr_i (pend_q[DIDX_W-1:0]),
    .wdata_i (det_wdata),
    .raddr_i (det_raddr),
    .rdata_o (det_rdata)
  );

  logic in_fire;
  logic emit_fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign det_we = in_fire && (cmd_e'(cmd_i) == CMD_DET) && (pend_q != DETS_FULL);
  assign det_wdata = '{x: box_x_i, y: box_y_i, w: box_width_i, h: box_height_i,
                       kind: det_class_i};

  // distance scan datapath
  logic signed [COORD_BITS:0]     dx;
  logic signed [COORD_BITS:0]     dy;
  logic signed [2*COORD_BITS+1:0] sqx_full;
  logic signed [2*COORD_BITS+1:0] sqy_full;
  logic                           eligible;
  logic [DIST_W-1:0]              dsum;
  logic                           closer;
  logic                           scan_done;

  assign dx       = $signed({1'b0, det_rdata.x}) - $signed({1'b0, trk_q.nx});
  assign dy       = $signed({1'b0, det_rdata.y}) - $signed({1'b0, trk_q.ny});
  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign eligible = !taken_q[rd_j_q] && (det_rdata.kind == trk_q.kind);
  assign dsum     = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
  assign closer   = s2_v_q && s2_el_q && (CMP_W'(dsum) < best_q);
  assign scan_done = (iss_q == pend_q) && !rd_v_q && !s2_v_q;

  // prune and append checks
  logic [TIME_W-1:0]        age;
  logic signed [TIME_W:0]   age_s;
  logic signed [TIME_W:0]   tout_s;
  logic                     stale;
  logic                     a_free;
  logic                     a_full;

  assign age    = now_q - trk_rdata.ntime;
  assign age_s  = $signed({age[TIME_W-1], age});
  assign tout_s = $signed((TIME_W + 1)'(tout_q));
  assign stale  = age_s > tout_s;
  assign a_free = !taken_q[aj_q[DIDX_W-1:0]];
  assign a_full = (tt_q == TRACKS_FULL);

  // extrapolation datapath
  logic [COORD_BITS-1:0]      c1;
  logic [COORD_BITS-1:0]      c0;
  logic signed [COORD_BITS:0] c1s;
  logic signed [COORD_BITS:0] cdiff;
  logic signed [PROD_W-1:0]   p1;
  logic signed [PROD_W-1:0]   p2;
  logic [TIME_W-1:0]          dt_c;
  logic [NUM_W-1:0]           num_mag;
  logic [DEN_W-1:0]           dt_mag;
  logic                       div_start;
  logic                       div_done;
  logic [NUM_W-1:0]           quo;
  logic signed [EST_W-1:0]    q_sat;

  assign c1    = coord_q ? trk_q.ny : trk_q.nx;
  assign c0    = coord_q ? trk_q.py : trk_q.px;
  assign c1s   = $signed({1'b0, c1});
  assign cdiff = c1s - $signed({1'b0, c0});
  assign p1    = c1s * dt_q;
  assign p2    = cdiff * e_q;
  assign dt_c  = trk_q.ntime - trk_q.ptime;
  assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign dt_mag  = dt_q[TIME_W-1] ? DEN_W'(-dt_q) : DEN_W'(dt_q);
  assign div_start = (state_q == S_X_GO);

  gnta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (dt_mag),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    if (neg_q) begin
      q_sat = (quo > NEG_LIMIT) ? EST_MIN : -$signed(quo[EST_W-1:0]);
    end else begin
      q_sat = (quo > POS_LIMIT) ? EST_MAX : $signed(quo[EST_W-1:0]);
    end
  end

  // track and detection ram port control
  always_comb begin
    trk_raddr = ti_q[TIDX_W-1:0];
    det_raddr = iss_q[DIDX_W-1:0];
    trk_we    = 1'b0;
    trk_waddr = ti_q[TIDX_W-1:0];
    trk_wdata = trk_rdata;
    unique case (state_q)
      S_X_RD: begin
        trk_raddr = idx_q;
      end
      S_A_RD: begin
        det_raddr = aj_q[DIDX_W-1:0];
      end
      S_E_TWR: begin
        trk_we          = pick_v_q;
        trk_wdata       = trk_q;
        trk_wdata.px    = trk_q.nx;
        trk_wdata.py    = trk_q.ny;
        trk_wdata.ptime = trk_q.ntime;
        trk_wdata.nx    = pick_det_q.x;
        trk_wdata.ny    = pick_det_q.y;
        trk_wdata.nw    = pick_det_q.w;
        trk_wdata.nh    = pick_det_q.h;
        trk_wdata.ntime = now_q;
        trk_wdata.cnt   = (trk_q.cnt < CNT_SAT) ? trk_q.cnt + 2'd1 : trk_q.cnt;
      end
      S_A_CHK: begin
        trk_we    = a_free && !a_full;
        trk_waddr = tt_q[TIDX_W-1:0];
        trk_wdata = '{kind: det_rdata.kind, nx: det_rdata.x, ny: det_rdata.y,
                      nw: det_rdata.w, nh: det_rdata.h, ntime: now_q,
                      px: '0, py: '0, ptime: '0, cnt: 2'd1};
      end
      S_P_CHK: begin
        trk_we    = !stale;
        trk_waddr = wi_q[TIDX_W-1:0];
      end
      default: begin
        trk_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tt_q        <= '0;
      pend_q      <= '0;
      taken_q     <= '0;
      rd_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q   <= cmd_e'(cmd_i);
            now_q   <= time_now_i;
            idx_q   <= track_index_i;
            ti_q    <= '0;
            wi_q    <= '0;
            aj_q    <= '0;
            drop_q  <= 1'b0;
            taken_q <= '0;
            unique case (cmd_e'(cmd_i))
              CMD_DET: begin
                if (pend_q != DETS_FULL) begin
                  pend_q <= pend_q + DCNT_W'(1);
                  res_q  <= ST_OK;
                end else begin
                  res_q <= ST_DROPPED;
                end
                state_q <= S_EMIT;
              end
              CMD_EOF: begin
                res_q <= ST_OK;
                if (tt_q != '0) begin
                  state_q <= S_E_TRD;
                end else if (pend_q != '0) begin
                  state_q <= S_A_RD;
                end else begin
                  state_q <= S_EMIT;
                end
              end
              CMD_PRUNE: begin
                res_q   <= ST_OK;
                state_q <= (tt_q != '0) ? S_P_RD : S_EMIT;
              end
              CMD_EXTRAP: begin
                if (TCNT_W'(track_index_i) >= tt_q) begin
                  res_q   <= ST_NO_TRACK;
                  state_q <= S_EMIT;
                end else begin
                  res_q   <= ST_OK;
                  state_q <= S_X_RD;
                end
              end
              default: begin
                res_q   <= ST_OK;
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_E_TRD: begin
          state_q <= S_E_TLD;
        end
        S_E_TLD: begin
          trk_q    <= trk_rdata;
          best_q   <= CMP_W'(gate_q);
          pick_v_q <= 1'b0;
          iss_q    <= '0;
          rd_v_q   <= 1'b0;
          s2_v_q   <= 1'b0;
          state_q  <= S_E_SCAN;
        end
        S_E_SCAN: begin
          rd_v_q   <= (iss_q != pend_q);
          rd_j_q   <= iss_q[DIDX_W-1:0];
          if (iss_q != pend_q) begin
            iss_q <= iss_q + DCNT_W'(1);
          end
          s2_v_q   <= rd_v_q;
          s2_el_q  <= eligible;
          s2_j_q   <= rd_j_q;
          s2_sqx_q <= sqx_full[SQ_W-1:0];
          s2_sqy_q <= sqy_full[SQ_W-1:0];
          s2_det_q <= det_rdata;
          if (closer) begin
            best_q     <= CMP_W'(dsum);
            pick_v_q   <= 1'b1;
            pick_j_q   <= s2_j_q;
            pick_det_q <= s2_det_q;
          end
          if (scan_done) begin
            state_q <= S_E_TWR;
          end
        end
        S_E_TWR: begin
          if (pick_v_q) begin
            taken_q[pick_j_q] <= 1'b1;
          end
          ti_q <= ti_q + TCNT_W'(1);
          if (ti_q + TCNT_W'(1) < tt_q) begin
            state_q <= S_E_TRD;
          end else if (pend_q != '0) begin
            state_q <= S_A_RD;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_A_RD: begin
          state_q <= S_A_CHK;
        end
        S_A_CHK: begin
          if (a_free && !a_full) begin
            tt_q <= tt_q + TCNT_W'(1);
          end
          if (a_free && a_full) begin
            drop_q <= 1'b1;
          end
          aj_q <= aj_q + DCNT_W'(1);
          if (aj_q + DCNT_W'(1) < pend_q) begin
            state_q <= S_A_RD;
          end else begin
            pend_q  <= '0;
            taken_q <= '0;
            res_q   <= (drop_q || (a_free && a_full)) ? ST_DROPPED : ST_OK;
            state_q <= S_EMIT;
          end
        end
        S_P_RD: begin
          state_q <= S_P_CHK;
        end
        S_P_CHK: begin
          if (!stale) begin
            wi_q <= wi_q + TCNT_W'(1);
          end
          ti_q <= ti_q + TCNT_W'(1);
          if (ti_q + TCNT_W'(1) < tt_q) begin
            state_q <= S_P_RD;
          end else begin
            tt_q    <= wi_q + TCNT_W'(!stale);
            state_q <= S_EMIT;
          end
        end
        S_X_RD: begin
          state_q <= S_X_LD;
        end
        S_X_LD: begin
          trk_q   <= trk_rdata;
          state_q <= S_X_CHK;
        end
        S_X_CHK: begin
          dt_q    <= $signed(dt_c);
          e_q     <= $signed(now_q - trk_q.ntime);
          coord_q <= 1'b0;
          if (trk_q.cnt < CNT_SAT) begin
            res_q   <= ST_FEW_SIGHTINGS;
            state_q <= S_EMIT;
          end else if (dt_c == '0) begin
            res_q   <= ST_ZERO_DT;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_X_MUL;
          end
        end
        S_X_MUL: begin
          p1_q    <= p1;
          p2_q    <= p2;
          state_q <= S_X_SUM;
        end
        S_X_SUM: begin
          num_q   <= $signed({p1_q[PROD_W-1], p1_q}) + $signed({p2_q[PROD_W-1], p2_q});
          state_q <= S_X_GO;
        end
        S_X_GO: begin
          neg_q   <= num_q[NUM_W-1] ^ dt_q[TIME_W-1];
          state_q <= S_X_DIV;
        end
        S_X_DIV: begin
          if (div_done) begin
            state_q <= S_X_SAT;
          end
        end
        S_X_SAT: begin
          if (!coord_q) begin
            est_x_q <= q_sat;
            coord_q <= 1'b1;
            state_q <= S_X_MUL;
          end else begin
            est_y_q <= q_sat;
            res_q   <= ST_OK;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_status_q <= res_q;
            out_live_q   <= tt_q;
            if (cmd_q == CMD_EXTRAP && res_q == ST_OK) begin
              out_x_q <= est_x_q;
              out_y_q <= est_y_q;
              out_w_q <= trk_q.nw;
              out_h_q <= trk_q.nh;
              out_k_q <= trk_q.kind;
            end else begin
              out_x_q <= '0;
              out_y_q <= '0;
              out_w_q <= '0;
              out_h_q <= '0;
              out_k_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign est_x_o       = out_x_q;
  assign est_y_o       = out_y_q;
  assign est_width_o   = out_w_q;
  assign est_height_o  = out_h_q;
  assign est_class_o   = out_k_q;
  assign live_tracks_o = out_live_q;

`ifndef SYNTHESIS
  a_tt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tt_q <= TRACKS_FULL)
    else $error("track count above table depth");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= DETS_FULL)
    else $error("pending count above buffer depth");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second beat taken while an item is in flight");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_X_DIV))
    else $error("divider finished outside the divide step");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_CHK) && !(aj_q + DCNT_W'(1) < pend_q) |=> (pend_q == '0))
    else $error("detection buffer not emptied at end of frame");
`endif

endmodule

`default_nettype wire
